FILE: design/bate_pkg.sv
package bate_pkg;

  // table geometry
  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int VAL_W = 32;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // reduction tree: groups of cells, then a final pick over groups
  localparam int GRP   = 8;
  localparam int GRP_W = $clog2(GRP);
  localparam int NGRP  = DEPTH / GRP;

  // command codes
  localparam logic [2:0] OP_FIND   = 3'd0;
  localparam logic [2:0] OP_MODIFY = 3'd1;
  localparam logic [2:0] OP_APPEND = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    logic                    valid;
    logic [2:0]              op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic                    ok;    // index below count
    logic                    room;  // count below depth
  } bcast_t;

  // reduced answer from the cell row
  typedef struct packed {
    logic                    hit;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] data;
  } red_t;

endpackage

FILE: design/bate_cell.sv
module bate_cell (
  input  logic                             clk,
  input  bate_pkg::bcast_t                 bc,
  input  logic [bate_pkg::IDX_W-1:0]       pos,
  input  logic signed [bate_pkg::VAL_W-1:0] next_value,
  output logic signed [bate_pkg::VAL_W-1:0] value_out,
  output logic                             match,
  output logic signed [bate_pkg::VAL_W-1:0] tap
);

  logic signed [bate_pkg::VAL_W-1:0] entry;
  logic [bate_pkg::CNT_W-1:0]        pos_c;
  logic                              in_use;
  logic                              at_idx;
  logic                              at_cnt;
  logic                              below_idx;
  logic                              below_last;

  // position relative to the command
  assign pos_c      = {1'b0, pos};
  assign in_use     = pos_c < bc.count;
  assign at_idx     = pos == bc.index;
  assign at_cnt     = pos_c == bc.count;
  assign below_idx  = pos < bc.index;
  assign below_last = (pos_c + bate_pkg::CNT_W'(1)) < bc.count;

  assign value_out = entry;

  // entry update, compare and read tap
  always_ff @(posedge clk) begin
    if (bc.valid) begin
      match <= in_use && (entry == bc.value);
      tap   <= (bc.op == bate_pkg::OP_MODIFY && at_idx) ? entry : '0;
      case (bc.op)
        bate_pkg::OP_MODIFY: if (bc.ok && at_idx) entry <= bc.value;
        bate_pkg::OP_CLEAR:  if (bc.ok && at_idx) entry <= '0;
        bate_pkg::OP_APPEND: if (bc.room && at_cnt) entry <= bc.value;
        bate_pkg::OP_REMOVE: if (bc.ok && !below_idx && below_last) entry <= next_value;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/bate_reduce.sv
module bate_reduce (
  input  logic                              clk,
  input  logic                              en,
  input  logic [bate_pkg::DEPTH-1:0]        match,
  input  logic signed [bate_pkg::VAL_W-1:0] tap [bate_pkg::DEPTH],
  output bate_pkg::red_t                    res
);

  logic                              grp_hit   [bate_pkg::NGRP];
  logic [bate_pkg::GRP_W-1:0]        grp_idx   [bate_pkg::NGRP];
  logic signed [bate_pkg::VAL_W-1:0] grp_data  [bate_pkg::NGRP];
  logic                              hit_next  [bate_pkg::NGRP];
  logic [bate_pkg::GRP_W-1:0]        idx_next  [bate_pkg::NGRP];
  logic signed [bate_pkg::VAL_W-1:0] data_next [bate_pkg::NGRP];

  // first level: lowest match and OR of taps inside each group
  always_comb begin
    for (int g = 0; g < bate_pkg::NGRP; g++) begin
      hit_next[g]  = 1'b0;
      idx_next[g]  = '0;
      data_next[g] = '0;
      for (int k = bate_pkg::GRP - 1; k >= 0; k--) begin
        if (match[g*bate_pkg::GRP + k]) begin
          hit_next[g] = 1'b1;
          idx_next[g] = bate_pkg::GRP_W'(k);
        end
        data_next[g] = data_next[g] | tap[g*bate_pkg::GRP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < bate_pkg::NGRP; g++) begin
        grp_hit[g]  <= hit_next[g];
        grp_idx[g]  <= idx_next[g];
        grp_data[g] <= data_next[g];
      end
    end
  end

  // second level: lowest hit group wins, taps OR together
  always_comb begin
    res = '0;
    for (int g = bate_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        res.hit   = 1'b1;
        res.index = {(bate_pkg::IDX_W - bate_pkg::GRP_W)'(g), grp_idx[g]};
      end
    end
    for (int g = 0; g < bate_pkg::NGRP; g++) begin
      res.data = res.data | grp_data[g];
    end
  end

endmodule

FILE: design/bounded_array_table_engine_top.sv
// Packed table of signed 32-bit entries with a valid count, 128 entries deep.
// Each command item on the slave stream gives exactly one result item on the
// master stream: find (lowest matching position), modify (returns old value),
// append, clear to zero, and remove (later entries shift down one position).
// Range errors and appends to a full table leave the table unchanged.
//
// The table is a row of cells, one entry each; a remove moves every later
// entry into its lower neighbor together. Compare results and the read tap
// go through a two-level tree (groups of 8 cells) with a registered group level.
//
// An accepted command passes the cell registers (broadcast to the cells),
// the group level and the final pick into the output register; the next
// command waits for this pass through the cell row and the reduction tree,
// so only one command is in flight at a time.
// Reset (rst, synchronous) empties the table and drops any pending result;
// entries keep stale data but are never read before being rewritten.
// When the receiver stalls, the result holds in the output register; one more
// command is accepted and processed, then waits for the register to drain.
module bounded_array_table_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op[2:0], index[9:3], value[41:10], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // status[1:0], found_index[8:2],
                                     // old_value[40:9], entry_count[48:41], pad
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CELL = 4'b0010,
    S_GRP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                            state, state_next;
  logic [2:0]                        cmd_op;
  logic [bate_pkg::IDX_W-1:0]        cmd_index;
  logic signed [bate_pkg::VAL_W-1:0] cmd_value;
  logic [bate_pkg::CNT_W-1:0]        count;
  logic [1:0]                        saved_status;
  logic [1:0]                        status_next;
  logic                              in_accept;
  logic                              out_load;
  bate_pkg::bcast_t                  bc;
  bate_pkg::red_t                    red;

  logic signed [bate_pkg::VAL_W-1:0] row_value [bate_pkg::DEPTH];
  logic signed [bate_pkg::VAL_W-1:0] row_tap   [bate_pkg::DEPTH];
  logic [bate_pkg::DEPTH-1:0]        row_match;

  logic [1:0]                        out_status;
  logic [bate_pkg::IDX_W-1:0]        out_index;
  logic signed [bate_pkg::VAL_W-1:0] out_old;
  logic [bate_pkg::CNT_W-1:0]        out_count;

  assign s_axis_tready = state == S_IDLE;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // command capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_op    <= s_axis_tdata[2:0];
      cmd_index <= s_axis_tdata[9:3];
      cmd_value <= s_axis_tdata[41:10];
    end
  end

  // broadcast to the cell row
  always_comb begin
    bc       = '0;
    bc.valid = state == S_CELL;
    bc.op    = cmd_op;
    bc.index = cmd_index;
    bc.value = cmd_value;
    bc.count = count;
    bc.ok    = {1'b0, cmd_index} < count;
    bc.room  = count < bate_pkg::DEPTH_CNT;
  end

  // status for everything but find
  always_comb begin
    case (cmd_op) inside
      bate_pkg::OP_MODIFY, bate_pkg::OP_CLEAR, bate_pkg::OP_REMOVE:
        status_next = bc.ok ? bate_pkg::ST_OK : bate_pkg::ST_RANGE;
      bate_pkg::OP_APPEND:
        status_next = bc.room ? bate_pkg::ST_OK : bate_pkg::ST_FULL;
      default:
        status_next = bate_pkg::ST_OK;
    endcase
  end

  // count and status, updated in the cell cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_CELL) begin
      if (cmd_op == bate_pkg::OP_APPEND && bc.room) begin
        count <= count + bate_pkg::CNT_W'(1);
      end else if (cmd_op == bate_pkg::OP_REMOVE && bc.ok) begin
        count <= count - bate_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CELL) saved_status <= status_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_CELL;
      S_CELL: state_next = S_GRP;
      S_GRP:  state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // cell row, each cell fed by its upper neighbor
  for (genvar i = 0; i < bate_pkg::DEPTH; i++) begin : g_cell
    logic signed [bate_pkg::VAL_W-1:0] next_value;
    if (i == bate_pkg::DEPTH - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_mid
      assign next_value = row_value[i+1];
    end
    bate_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .pos        (bate_pkg::IDX_W'(i)),
      .next_value (next_value),
      .value_out  (row_value[i]),
      .match      (row_match[i]),
      .tap        (row_tap[i])
    );
  end

  bate_reduce u_reduce (
    .clk   (clk),
    .en    (state == S_GRP),
    .match (row_match),
    .tap   (row_tap),
    .res   (red)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= saved_status;
      out_index  <= '0;
      out_old    <= '0;
      out_count  <= count;
      if (cmd_op == bate_pkg::OP_FIND) begin
        out_status <= red.hit ? bate_pkg::ST_OK : bate_pkg::ST_NOT_FOUND;
        out_index  <= red.hit ? red.index : '0;
      end
      if (cmd_op == bate_pkg::OP_MODIFY && saved_status == bate_pkg::ST_OK) begin
        out_old <= red.data;
      end
    end
  end

  assign m_axis_tdata = {7'd0, out_count, out_old, out_index, out_status};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bate_pkg::DEPTH_CNT)
    else $error("entry count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_CELL |=> count == $past(count))
    else $error("entry count changed outside the cell cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |=> count == $past(count) ||
      count == $past(count) + bate_pkg::CNT_W'(1) ||
      count == $past(count) - bate_pkg::CNT_W'(1))
    else $error("entry count moved by more than one");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid && state == S_IDLE)
    else $error("finished result not presented");

endmodule
